/* rtl/core/ufr_pkg.sv */
// ----------------------------------------------------------------------------
// ufr_pkg
// Shared types and constants of the UART frame receiver: payload beats,
// configuration register image and register indexes.
// ----------------------------------------------------------------------------
package ufr_pkg;

	// register map
	localparam int unsigned AddrWidth = 4;
	localparam int unsigned DataWidth = 32;

	typedef enum logic [1:0] {
		REG_HEADER_VALUE = 2'd0,
		REG_MIN_LENGTH   = 2'd1,
		REG_MAX_LENGTH   = 2'd2,
		REG_GAP_LIMIT    = 2'd3
	} reg_index_t;

	localparam logic [7:0] HeaderValueReset = 8'd0;
	localparam logic [7:0] MinLengthReset   = 8'd6;
	localparam logic [7:0] MaxLengthReset   = 8'd64;
	localparam logic [7:0] GapLimitReset    = 8'd10;

	// configuration image handed to the frame tracker
	typedef struct packed {
		logic [7:0] header_value;
		logic [7:0] min_length;
		logic [7:0] max_length;
		logic [7:0] gap_limit;
	} cfg_t;

	// input beat
	typedef struct packed {
		logic [7:0] rx_byte;
		logic [7:0] gap_ticks;
	} in_item_t;

	// result beat
	typedef struct packed {
		logic       taken;
		logic [7:0] byte_index;
		logic [7:0] byte_out;
		logic       frame_end;
		logic       frame_good;
	} out_item_t;

endpackage

/* rtl/core/ufr_cfg.sv */
// ----------------------------------------------------------------------------
// ufr_cfg
// APB-style configuration registers: header value, length limits and gap
// limit. Writes land on the access cycle; reads return the register value.
// ----------------------------------------------------------------------------
module ufr_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ufr_pkg::AddrWidth-1:0]  paddr,
	input  logic [ufr_pkg::DataWidth-1:0]  pwdata,
	output logic [ufr_pkg::DataWidth-1:0]  prdata,
	output logic                           pready,
	output ufr_pkg::cfg_t                  cfg
);

	ufr_pkg::cfg_t      cfg_q;
	ufr_pkg::reg_index_t reg_idx;
	logic               wr_en;

	assign reg_idx = ufr_pkg::reg_index_t'(paddr[3:2]);
	assign wr_en   = psel & penable & pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	// write the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_value <= ufr_pkg::HeaderValueReset;
			cfg_q.min_length   <= ufr_pkg::MinLengthReset;
			cfg_q.max_length   <= ufr_pkg::MaxLengthReset;
			cfg_q.gap_limit    <= ufr_pkg::GapLimitReset;
		end else if (wr_en) begin
			unique case (reg_idx)
				ufr_pkg::REG_HEADER_VALUE: cfg_q.header_value <= pwdata[7:0];
				ufr_pkg::REG_MIN_LENGTH:   cfg_q.min_length   <= pwdata[7:0];
				ufr_pkg::REG_MAX_LENGTH:   cfg_q.max_length   <= pwdata[7:0];
				ufr_pkg::REG_GAP_LIMIT:    cfg_q.gap_limit    <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// read back the addressed register
	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			ufr_pkg::REG_HEADER_VALUE: prdata[7:0] = cfg_q.header_value;
			ufr_pkg::REG_MIN_LENGTH:   prdata[7:0] = cfg_q.min_length;
			ufr_pkg::REG_MAX_LENGTH:   prdata[7:0] = cfg_q.max_length;
			ufr_pkg::REG_GAP_LIMIT:    prdata[7:0] = cfg_q.gap_limit;
			default:                   prdata      = '0;
		endcase
	end

endmodule

/* rtl/core/ufr_track.sv */
// ----------------------------------------------------------------------------
// ufr_track
// Frame tracking state (byte count, frame length, running sum) and the
// single-pass step logic that turns one received byte into one result beat.
// ----------------------------------------------------------------------------
module ufr_track (
	input  logic                clk,
	input  logic                arst_n,
	input  ufr_pkg::cfg_t       cfg,
	input  ufr_pkg::in_item_t   item,
	input  logic                advance,
	output ufr_pkg::out_item_t  result
);

	logic [8:0] byte_count_q;
	logic [7:0] frame_length_q;
	logic [7:0] running_sum_q;

	logic [8:0] count_n;
	logic [7:0] length_n;
	logic [7:0] sum_n;

	logic       gap_reset;
	logic [8:0] count_cur;
	logic [7:0] sum_cur;
	logic [7:0] sum_add;
	logic [8:0] count_inc;
	logic [8:0] end_mark;

	// drop back to hunting on a long gap, then apply the byte
	always_comb begin
		gap_reset = (item.gap_ticks >= cfg.gap_limit);
		count_cur = gap_reset ? 9'd0 : byte_count_q;
		sum_cur   = gap_reset ? 8'd0 : running_sum_q;
		sum_add   = sum_cur + item.rx_byte;
		count_inc = count_cur + 9'd1;
		end_mark  = {1'b0, frame_length_q} + 9'd1;

		count_n   = count_cur;
		length_n  = frame_length_q;
		sum_n     = sum_cur;
		result    = '0;

		if (count_cur == 9'd0) begin
			// hunting: take only the header byte
			if (item.rx_byte == cfg.header_value) begin
				result.taken      = 1'b1;
				result.byte_index = 8'd0;
				result.byte_out   = item.rx_byte;
				sum_n             = 8'd0;
				count_n           = 9'd1;
			end
		end else if (count_cur == 9'd1) begin
			// length byte: reject out of range, else start the sum
			if (item.rx_byte > cfg.max_length || item.rx_byte < cfg.min_length) begin
				count_n = 9'd0;
				sum_n   = 8'd0;
			end else begin
				result.taken      = 1'b1;
				result.byte_index = 8'd1;
				result.byte_out   = item.rx_byte;
				length_n          = item.rx_byte;
				sum_n             = item.rx_byte;
				count_n           = 9'd2;
			end
		end else begin
			// body byte: accumulate and close the frame at length+1 bytes
			result.taken      = 1'b1;
			result.byte_index = count_cur[7:0];
			result.byte_out   = item.rx_byte;
			sum_n             = sum_add;
			count_n           = count_inc;
			if (count_inc >= end_mark || count_inc < 9'd2) begin
				result.frame_end  = 1'b1;
				result.frame_good = (sum_add == 8'd0);
				count_n           = 9'd0;
				sum_n             = 8'd0;
			end
		end
	end

	// hold state until the beat moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q   <= 9'd0;
			frame_length_q <= 8'd0;
			running_sum_q  <= 8'd0;
		end else if (advance) begin
			byte_count_q   <= count_n;
			frame_length_q <= length_n;
			running_sum_q  <= sum_n;
		end
	end

endmodule

/* rtl/core/uart_frame_receiver.sv */
// ----------------------------------------------------------------------------
// uart_frame_receiver
// Header/length/checksum frame receiver for a byte stream from a UART.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : in_valid/in_stall/in_data, one received byte and the idle
//                 gap in ticks since the previous byte per beat.
//   out channel : out_valid/out_stall/out_data, exactly one result beat per
//                 input beat, in order: taken flag, byte index, echoed byte,
//                 frame end and checksum verdict.
//   config port : APB-style, four 8-bit registers at byte addresses 0, 4, 8,
//                 12 (header, min length, max length, gap limit). Write only
//                 while no beat is in flight.
// Each accepted beat sits in the input register, then moves into the result
// register, which drives out_valid, once that register can load.
// Throughput is one beat per cycle while out_stall is low; the frame state
// (count, length, running sum) updates once per beat as the beat moves from
// the input register into the result register.
// Reset clears both stages, restores register defaults and puts the
// receiver in header hunting. While out_stall is high the result beat holds,
// the input register fills once, and then in_stall rises.
// ----------------------------------------------------------------------------
module uart_frame_receiver (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ufr_pkg::AddrWidth-1:0]  paddr,
	input  logic [ufr_pkg::DataWidth-1:0]  pwdata,
	output logic [ufr_pkg::DataWidth-1:0]  prdata,
	output logic                           pready,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  ufr_pkg::in_item_t              in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output ufr_pkg::out_item_t             out_data
);

	ufr_pkg::cfg_t      cfg;
	ufr_pkg::in_item_t  item_s1;
	logic               valid_s1;
	ufr_pkg::out_item_t result;
	ufr_pkg::out_item_t result_s2;
	logic               valid_s2;
	logic               load_s2;
	logic               load_s1;
	logic               advance;

	ufr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// pipeline flow control
	assign load_s2  = !valid_s2 || !out_stall;
	assign load_s1  = !valid_s1 || load_s2;
	assign advance  = valid_s1 && load_s2;
	assign in_stall = !load_s1;

	ufr_track u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.item    (item_s1),
		.advance (advance),
		.result  (result)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = result_s2;

	// checks
	a_end_is_taken: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_end |-> out_data.taken)
		else $error("frame end on a byte that was not taken");

	a_good_needs_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_good |-> out_data.frame_end)
		else $error("frame good without frame end");

	a_dropped_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.taken |->
		out_data.byte_index == 8'd0 && out_data.byte_out == 8'd0)
		else $error("dropped byte carries nonzero fields");

	a_stall_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_stall)
		else $error("input stalled with room in the pipeline");

endmodule
